// ===== rtl/core/approx_atan2_unit_macros.svh =====
// Assertion macros for the approx_atan2_unit checker.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef APPROX_ATAN2_UNIT_MACROS_SVH
`define APPROX_ATAN2_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define AA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("approx_atan2_unit check failed");

// Consequent checked in the cycle after the antecedent.
`define AA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("approx_atan2_unit check failed");

`endif

// ===== rtl/core/aa_pkg.sv =====
// Shared constants and types for the approx_atan2_unit block.
// No dependencies.
package aa_pkg;

    localparam int INPUT_WIDTH_DEF = 16;
    localparam int ANGLE_FRAC_DEF  = 13;

    // ratio z = min/max, unsigned Q0.16
    localparam int Z_BITS  = 16;
    // angle before rounding, Q2.32 magnitude
    localparam int TH_BITS = 34;

    localparam logic [Z_BITS-1:0]  Z_MAX       = '1;
    localparam logic [Z_BITS-1:0]  COEF_N1     = 16'd63727;
    localparam logic [13:0]        COEF_N2_MAG = 14'd12580;
    localparam logic [TH_BITS-1:0] HALF_PI_Q32 = 34'd6746518852;
    localparam logic [TH_BITS-1:0] PI_Q32      = 34'd13493037705;

    // per-item octant and special-case flags that travel with the data
    typedef struct packed {
        logic steep;   // |y| > |x|
        logic xneg;
        logic yneg;
        logic zero;    // both inputs zero
        logic equal;   // |y| == |x|, ratio saturates
    } side_t;

endpackage

// ===== rtl/core/aa_in_if.sv =====
// Input stream interface: one (x_coord, y_coord) vector per transfer.
// Depends on aa_pkg.
interface aa_in_if
    import aa_pkg::*;
#(
    parameter int INPUT_WIDTH = INPUT_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [INPUT_WIDTH-1:0] x_coord;
    logic signed [INPUT_WIDTH-1:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// ===== rtl/core/aa_out_if.sv =====
// Output stream interface: one angle result per transfer.
// Depends on aa_pkg.
interface aa_out_if
    import aa_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
);
    localparam int ANGLE_WIDTH = ANGLE_FRAC_BITS + 3;

    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] angle;
    logic                          zero_vector;

    modport source (output valid, output angle, output zero_vector, input ready);
    modport sink   (input valid, input angle, input zero_vector, output ready);
endinterface

// ===== rtl/core/aa_div_cell.sv =====
// One restoring-division cell: produces one quotient bit of z per item.
// Depends on aa_pkg.
module aa_div_cell
    import aa_pkg::*;
#(
    parameter int INPUT_WIDTH = INPUT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  logic [INPUT_WIDTH-1:0] up_rem,
    input  logic [INPUT_WIDTH-1:0] up_den,
    input  logic [Z_BITS-1:0]      up_quo,
    input  side_t                  up_side,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output logic [INPUT_WIDTH-1:0] dn_rem,
    output logic [INPUT_WIDTH-1:0] dn_den,
    output logic [Z_BITS-1:0]      dn_quo,
    output side_t                  dn_side
);

    logic                   valid_reg;
    logic [INPUT_WIDTH-1:0] rem_reg;
    logic [INPUT_WIDTH-1:0] den_reg;
    logic [Z_BITS-1:0]      quo_reg;
    side_t                  side_reg;

    logic [INPUT_WIDTH:0]   shifted;
    logic [INPUT_WIDTH:0]   diff;
    logic                   fits;
    logic [INPUT_WIDTH-1:0] rem_next;
    logic [Z_BITS-1:0]      quo_next;

    // rem < den holds on entry (except the lo == hi cases), so 2*rem - den stays below den
    assign shifted  = {up_rem, 1'b0};
    assign diff     = shifted - {1'b0, up_den};
    assign fits     = (shifted >= {1'b0, up_den});
    assign rem_next = fits ? diff[INPUT_WIDTH-1:0] : shifted[INPUT_WIDTH-1:0];
    assign quo_next = {up_quo[Z_BITS-2:0], fits};

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_reg  <= rem_next;
            den_reg  <= up_den;
            quo_reg  <= quo_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_den   = den_reg;
    assign dn_quo   = quo_reg;
    assign dn_side  = side_reg;

endmodule

// ===== rtl/core/aa_tail.sv =====
// Polynomial, octant reflection and rounding stages after the divider chain.
// Depends on aa_pkg and aa_out_if.
module aa_tail
    import aa_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [Z_BITS-1:0] up_quo,
    input  side_t             up_side,
    aa_out_if.source          ang
);

    localparam int NSTAGE      = 5;
    localparam int ANGLE_WIDTH = ANGLE_FRAC_BITS + 3;
    localparam int SHIFT       = 32 - ANGLE_FRAC_BITS;
    localparam logic [TH_BITS:0] ROUND_ADD = (TH_BITS+1)'(1) << (31 - ANGLE_FRAC_BITS);

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_in;
    logic [NSTAGE:0]   rdy;

    // stage A: ratio and its square
    logic [Z_BITS-1:0]   za_next;
    logic [2*Z_BITS-1:0] sq_prod;
    logic [Z_BITS-1:0]   za_reg;
    logic [Z_BITS-1:0]   z2a_reg;
    side_t               sa_reg;
    // stage B: poly = N1 - N2*z^2
    logic [Z_BITS+13:0]  n2_prod;
    logic [Z_BITS-1:0]   poly_next;
    logic [Z_BITS-1:0]   polyb_reg;
    logic [Z_BITS-1:0]   zb_reg;
    side_t               sb_reg;
    // stage C: th = poly*z
    logic [2*Z_BITS-1:0] thc_reg;
    side_t               sc_reg;
    // stage D: reflections
    logic [TH_BITS-1:0]  th_steep;
    logic [TH_BITS-1:0]  thd_next;
    logic [TH_BITS-1:0]  thd_reg;
    side_t               sd_reg;
    // stage E: round, sign, output register
    logic [TH_BITS:0]     rsum;
    logic [TH_BITS:0]     rshift;
    logic [ANGLE_WIDTH-1:0] mag;
    logic [ANGLE_WIDTH-1:0] angle_next;
    logic [ANGLE_WIDTH-1:0] angle_reg;
    logic                   zero_reg;

    always_comb
    begin
        rdy[NSTAGE] = ang.ready;
        for (int i = NSTAGE - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end
    assign up_ready = rdy[0];

    // valid bit each stage would take from its upstream neighbor
    assign valid_in = {valid_reg[NSTAGE-2:0], up_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTAGE; i++)
            begin
                if (rdy[i])
                begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    assign za_next   = up_side.equal ? Z_MAX : up_quo;
    assign sq_prod   = za_next * za_next;
    assign n2_prod   = COEF_N2_MAG * z2a_reg;
    assign poly_next = COEF_N1 - {2'b00, n2_prod[Z_BITS+13:Z_BITS]};
    assign th_steep  = sc_reg.steep ? (HALF_PI_Q32 - {2'b00, thc_reg}) : {2'b00, thc_reg};
    assign thd_next  = sc_reg.xneg ? (PI_Q32 - th_steep) : th_steep;
    assign rsum      = {1'b0, thd_reg} + ROUND_ADD;
    assign rshift    = rsum >> SHIFT;
    assign mag       = rshift[ANGLE_WIDTH-1:0];

    always_comb
    begin
        if (sd_reg.zero)
        begin
            angle_next = '0;
        end
        else if (sd_reg.yneg)
        begin
            angle_next = '0 - mag;
        end
        else
        begin
            angle_next = mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            za_reg  <= za_next;
            z2a_reg <= sq_prod[2*Z_BITS-1:Z_BITS];
            sa_reg  <= up_side;
        end
        if (rdy[1])
        begin
            polyb_reg <= poly_next;
            zb_reg    <= za_reg;
            sb_reg    <= sa_reg;
        end
        if (rdy[2])
        begin
            thc_reg <= polyb_reg * zb_reg;
            sc_reg  <= sb_reg;
        end
        if (rdy[3])
        begin
            thd_reg <= thd_next;
            sd_reg  <= sc_reg;
        end
        if (rdy[4])
        begin
            angle_reg <= angle_next;
            zero_reg  <= sd_reg.zero;
        end
    end

    assign ang.valid       = valid_reg[NSTAGE-1];
    assign ang.angle       = angle_reg;
    assign ang.zero_vector = zero_reg;

endmodule

// ===== rtl/core/approx_atan2_unit.sv =====
// approx_atan2_unit: pipelined fixed-point atan2 with cubic approximation.
// Depends on aa_pkg, aa_in_if, aa_out_if, aa_div_cell and aa_tail.
//
// Use:
//   vec  sink channel, one (x_coord, y_coord) vector per transfer, signed
//        two's complement of INPUT_WIDTH bits each.
//   ang  source channel, one result per vector: angle in signed
//        Q2.ANGLE_FRAC_BITS radians over [-pi, pi], and zero_vector, set
//        (with angle forced to 0) when both inputs are zero.
//   ang valid follows the vec transfer through 22 register stages (one
//   operand stage, one cell per quotient bit of the 16-bit ratio, five
//   stages for the polynomial, octant reflection and rounding), the first
//   of them loaded at the transfer edge itself.
//   Throughput is one vector per cycle while ang does not stall; the
//   divider chain retires one quotient bit per cell, so every stage holds a different vector.
//   Every stage has its own valid bit and takes a new item whenever it is
//   empty or its neighbor takes its content, so a stall on ang fills the
//   bubbles first and vec keeps accepting until the whole chain is full.
//   Results leave in arrival order, none dropped or repeated.
//   Reset (rst_n low, asynchronous) empties all stages; nothing else needs
//   to be set up afterwards.
module approx_atan2_unit
    import aa_pkg::*;
#(
    parameter int INPUT_WIDTH     = INPUT_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    aa_in_if.sink     vec,
    aa_out_if.source  ang
);

    localparam logic [INPUT_WIDTH-1:0] ONE_W = INPUT_WIDTH'(1);

    // operand stage: magnitudes, octant flags, min/max split
    logic [INPUT_WIDTH-1:0] xu;
    logic [INPUT_WIDTH-1:0] yu;
    logic [INPUT_WIDTH-1:0] ax;
    logic [INPUT_WIDTH-1:0] ay;
    side_t                  side_next;
    logic                   front_valid_reg;
    logic [INPUT_WIDTH-1:0] lo_reg;
    logic [INPUT_WIDTH-1:0] hi_reg;
    side_t                  side_reg;

    // divider chain, index 0 is the operand stage output
    logic                   ch_valid [Z_BITS+1];
    logic                   ch_ready [Z_BITS+1];
    logic [INPUT_WIDTH-1:0] ch_rem   [Z_BITS+1];
    logic [INPUT_WIDTH-1:0] ch_den   [Z_BITS+1];
    logic [Z_BITS-1:0]      ch_quo   [Z_BITS+1];
    side_t                  ch_side  [Z_BITS+1];

    assign xu = vec.x_coord;
    assign yu = vec.y_coord;
    // most negative input maps to 2^(W-1), still exact in W unsigned bits
    assign ax = xu[INPUT_WIDTH-1] ? (~xu + ONE_W) : xu;
    assign ay = yu[INPUT_WIDTH-1] ? (~yu + ONE_W) : yu;

    assign side_next.steep = (ay > ax);
    assign side_next.xneg  = xu[INPUT_WIDTH-1];
    assign side_next.yneg  = yu[INPUT_WIDTH-1];
    assign side_next.zero  = (ax == '0) && (ay == '0);
    assign side_next.equal = (ax == ay);

    assign vec.ready = !front_valid_reg || ch_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (vec.ready)
        begin
            front_valid_reg <= vec.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vec.ready && vec.valid)
        begin
            lo_reg   <= side_next.steep ? ax : ay;
            hi_reg   <= side_next.steep ? ay : ax;
            side_reg <= side_next;
        end
    end

    assign ch_valid[0] = front_valid_reg;
    assign ch_rem[0]   = lo_reg;
    assign ch_den[0]   = hi_reg;
    assign ch_quo[0]   = '0;
    assign ch_side[0]  = side_reg;

    // one quotient bit of z = floor(lo * 2^16 / hi) per cell; the lo == hi
    // case is saturated later from the equal flag
    for (genvar k = 0; k < Z_BITS; k++)
    begin : g_div
        aa_div_cell #(
            .INPUT_WIDTH (INPUT_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (ch_valid[k]),
            .up_ready (ch_ready[k]),
            .up_rem   (ch_rem[k]),
            .up_den   (ch_den[k]),
            .up_quo   (ch_quo[k]),
            .up_side  (ch_side[k]),
            .dn_valid (ch_valid[k+1]),
            .dn_ready (ch_ready[k+1]),
            .dn_rem   (ch_rem[k+1]),
            .dn_den   (ch_den[k+1]),
            .dn_quo   (ch_quo[k+1]),
            .dn_side  (ch_side[k+1])
        );
    end

    // polynomial, reflections, rounding and the output register
    aa_tail #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_tail (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (ch_valid[Z_BITS]),
        .up_ready (ch_ready[Z_BITS]),
        .up_quo   (ch_quo[Z_BITS]),
        .up_side  (ch_side[Z_BITS]),
        .ang      (ang)
    );

endmodule

// ===== rtl/core/aa_checker.sv =====
// Port-level checks for approx_atan2_unit, attached by bind.
// Depends on aa_pkg and approx_atan2_unit_macros.svh.
`include "approx_atan2_unit_macros.svh"

module aa_checker
    import aa_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
)
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [ANGLE_FRAC_BITS+2:0]   angle,
    input logic                                zero_vector
);

    localparam int ANGLE_WIDTH = ANGLE_FRAC_BITS + 3;
    localparam logic [TH_BITS:0] PI_SUM =
        {1'b0, PI_Q32} + ((TH_BITS+1)'(1) << (31 - ANGLE_FRAC_BITS));
    localparam logic [TH_BITS:0] PI_SH = PI_SUM >> (32 - ANGLE_FRAC_BITS);
    localparam logic signed [ANGLE_WIDTH-1:0] PI_MAX = PI_SH[ANGLE_WIDTH-1:0];

    `AA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `AA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(angle) && $stable(zero_vector))
    `AA_ASSERT_NOW(a_zero_angle, out_valid && zero_vector, angle == '0)
    `AA_ASSERT_NOW(a_angle_range, out_valid, (angle <= PI_MAX) && (angle >= -PI_MAX))

endmodule

bind approx_atan2_unit aa_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_aa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (ang.valid),
    .out_ready   (ang.ready),
    .angle       (ang.angle),
    .zero_vector (ang.zero_vector)
);
